// ----- rtl/core/acb_pkg.sv -----
// Types and constants shared by the comment blanker modules.
package acb_pkg;

    // Scanner modes
    localparam logic [2:0] MODE_NORMAL           = 3'd0;
    localparam logic [2:0] MODE_LINE             = 3'd1;
    localparam logic [2:0] MODE_BLOCK            = 3'd2;
    localparam logic [2:0] MODE_PASS_THEN_NORMAL = 3'd3;
    localparam logic [2:0] MODE_BLANK_THEN_BLOCK = 3'd4;
    localparam logic [2:0] MODE_BLANK_THEN_NORM  = 3'd5;
    localparam logic [2:0] MODE_DONE             = 3'd6;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam logic [7:0] LINE_CHAR_RESET = 8'h40;

    // Output queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] text_quote;
        logic [7:0] comment_quote;
        logic       prev_bs;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        mode:          MODE_NORMAL,
        text_quote:    8'h00,
        comment_quote: 8'h00,
        prev_bs:       1'b0
    };

endpackage

// ----- rtl/core/acb_judge.sv -----
// One scanner step: judges a byte against its lookahead and updates the scan state.
module acb_judge
    import acb_pkg::*;
(
    input  t_scan      i_scan,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_next,
    input  logic [7:0] i_line_char,
    output t_scan      o_scan,
    output logic [7:0] o_byte
);

    logic [7:0] v_out;
    t_scan      v_scan;
    logic       v_special;

    always_comb begin
        v_out  = i_byte;
        v_scan = i_scan;
        v_special = (i_scan.mode == MODE_DONE) || (i_scan.mode == MODE_PASS_THEN_NORMAL) ||
                    (i_scan.mode == MODE_BLANK_THEN_BLOCK) ||
                    (i_scan.mode == MODE_BLANK_THEN_NORM);
        if (!v_special && i_byte == CH_NUL) begin
            v_scan.mode = MODE_DONE;
        end else begin
            unique case (i_scan.mode)
                MODE_DONE: begin
                end
                MODE_PASS_THEN_NORMAL: begin
                    v_scan.mode = MODE_NORMAL;
                end
                MODE_BLANK_THEN_BLOCK: begin
                    v_out       = CH_SPACE;
                    v_scan.mode = MODE_BLOCK;
                end
                MODE_BLANK_THEN_NORM: begin
                    v_out       = CH_SPACE;
                    v_scan.mode = MODE_NORMAL;
                end
                MODE_LINE: begin
                    if (i_byte == CH_NL) begin
                        v_scan.mode = MODE_NORMAL;
                    end else begin
                        v_out = CH_SPACE;
                    end
                end
                MODE_BLOCK: begin
                    v_out = (i_byte == CH_NL) ? i_byte : CH_SPACE;
                    if (i_scan.comment_quote != 8'h00) begin
                        if (i_byte == CH_BSLASH && i_next == i_scan.comment_quote) begin
                            v_out       = CH_SPACE;
                            v_scan.mode = MODE_BLANK_THEN_BLOCK;
                        end else if (i_byte == i_scan.comment_quote) begin
                            v_scan.comment_quote = 8'h00;
                        end
                    end else begin
                        if (i_byte == CH_STAR && i_next == CH_SLASH) begin
                            v_out       = CH_SPACE;
                            v_scan.mode = MODE_BLANK_THEN_NORM;
                        end else if (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE) begin
                            v_scan.comment_quote = i_byte;
                        end
                    end
                end
                default: begin
                    // normal text
                    v_scan.mode = MODE_NORMAL;
                    if (i_scan.text_quote != 8'h00) begin
                        if (i_byte == CH_BSLASH && i_next == i_scan.text_quote) begin
                            v_scan.mode = MODE_PASS_THEN_NORMAL;
                        end else if (i_byte == i_scan.text_quote) begin
                            v_scan.text_quote = 8'h00;
                        end
                    end else if (i_byte == i_line_char && !i_scan.prev_bs) begin
                        v_out       = CH_SPACE;
                        v_scan.mode = MODE_LINE;
                    end else if (i_byte == CH_SLASH && i_next == CH_STAR) begin
                        v_out                = CH_SPACE;
                        v_scan.comment_quote = 8'h00;
                        v_scan.mode          = MODE_BLANK_THEN_BLOCK;
                    end else if (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE) begin
                        v_scan.text_quote = i_byte;
                    end
                end
            endcase
        end
        v_scan.prev_bs = (v_out == CH_BSLASH);
    end

    assign o_scan = v_scan;
    assign o_byte = v_out;

endmodule

// ----- rtl/core/acb_out_fifo.sv -----
// Small result queue: up to two pushes and one pop per cycle.
module acb_out_fifo
    import acb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_out_item i_push0,
    input  t_out_item i_push1,
    output logic      o_room2,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_out_item            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;
    logic [FIFO_AW-1:0]   v_wr1;
    logic                 v_pop;

    assign v_wr1   = r_wr + 1'b1;
    assign v_pop   = o_valid & i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[v_wr1] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(i_push_cnt);
            r_rd  <= r_rd + FIFO_AW'(v_pop);
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push_cnt) - (FIFO_AW+1)'(v_pop);
        end
    end

endmodule

// ----- rtl/core/asm_comment_blanker.sv -----
// Top level of the streaming assembler comment blanker.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+------------------------------
//  input    | i_in_valid  | o_in_ready  | i_in_item  (in_byte, in_last)
//  output   | o_out_valid | i_out_ready | o_out_item (out_byte, out_last)
//  config   | i_cfg_we    | (none)      | i_cfg_data (line comment char)
//
// One input transaction per cycle while the queue has room. A byte is held as
// lookahead, so its result appears one transaction later; a last byte flushes
// the held byte, if any, and itself (up to two results) into the queue at the
// accepting edge, offered on consecutive output transactions after any earlier
// results. Scan state sits in registers, updated by the first of two chained
// judge steps; results go into a 4-entry queue. Input is taken while the queue
// has room for two results, so output stalls back up once three are queued.
// Synchronous active-low reset clears scan state, queue and the comment char
// (back to '@').
module asm_comment_blanker
    import acb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_line_char;
    t_scan      r_scan;
    logic [7:0] r_held;
    logic       r_held_valid;

    t_scan      v_scan_a;
    t_scan      v_scan_b;
    t_scan      v_scan_b_in;
    logic [7:0] v_byte_a;
    logic [7:0] v_byte_b;
    logic       v_accept;
    logic       v_room2;

    logic [1:0] v_push_cnt;
    t_out_item  v_push0;
    t_out_item  v_push1;

    assign v_accept   = i_in_valid & o_in_ready;
    assign o_in_ready = v_room2;

    // held byte judged with the incoming byte as lookahead
    acb_judge u_judge_held (
        .i_scan      (r_scan),
        .i_byte      (r_held),
        .i_next      (i_in_item.in_byte),
        .i_line_char (r_line_char),
        .o_scan      (v_scan_a),
        .o_byte      (v_byte_a)
    );

    // last byte judged against a NUL lookahead
    assign v_scan_b_in = r_held_valid ? v_scan_a : r_scan;

    acb_judge u_judge_last (
        .i_scan      (v_scan_b_in),
        .i_byte      (i_in_item.in_byte),
        .i_next      (CH_NUL),
        .i_line_char (r_line_char),
        .o_scan      (v_scan_b),
        .o_byte      (v_byte_b)
    );

    always_comb begin
        v_push_cnt = 2'd0;
        v_push0    = '{out_byte: v_byte_a, out_last: 1'b0};
        v_push1    = '{out_byte: v_byte_b, out_last: 1'b1};
        if (v_accept) begin
            if (r_held_valid) begin
                v_push_cnt = i_in_item.in_last ? 2'd2 : 2'd1;
            end else if (i_in_item.in_last) begin
                v_push_cnt = 2'd1;
                v_push0    = v_push1;
            end
        end
    end

    acb_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (v_push_cnt),
        .i_push0    (v_push0),
        .i_push1    (v_push1),
        .o_room2    (v_room2),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

    // held byte payload: no reset needed, guarded by r_held_valid
    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_held <= i_in_item.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_char  <= LINE_CHAR_RESET;
            r_scan       <= SCAN_RESET;
            r_held_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_line_char <= i_cfg_data;
            end
            if (v_accept) begin
                if (i_in_item.in_last) begin
                    // end of text: scanner back to its reset state
                    r_scan       <= SCAN_RESET;
                    r_held_valid <= 1'b0;
                end else begin
                    r_scan       <= r_held_valid ? v_scan_a : r_scan;
                    r_held_valid <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- bench/acb_blank_checker.sv -----
// Checker for the comment blanker: predicts the blanked byte stream and compares it with the output.
module acb_blank_checker
    import acb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor copy of the scanner
    logic [7:0] comment_char = LINE_CHAR_RESET;
    logic [2:0] mode         = MODE_NORMAL;
    logic [7:0] str_quote    = CH_NUL;
    logic [7:0] cmt_quote    = CH_NUL;
    logic [7:0] look_byte    = CH_NUL;
    logic       look_full    = 1'b0;
    logic       last_was_bs  = 1'b0;

    t_out_item blanked_q[$];
    int        fails = 0;

    function automatic void clear_scan();
        mode        = MODE_NORMAL;
        str_quote   = CH_NUL;
        cmt_quote   = CH_NUL;
        look_byte   = CH_NUL;
        look_full   = 1'b0;
        last_was_bs = 1'b0;
    endfunction

    // byte b as emitted, nxt is the lookahead
    function automatic logic [7:0] blank_byte(input logic [7:0] b, input logic [7:0] nxt);
        logic [7:0] res;
        res = b;
        if (mode != MODE_DONE && mode != MODE_PASS_THEN_NORMAL &&
            mode != MODE_BLANK_THEN_BLOCK && mode != MODE_BLANK_THEN_NORM && b == CH_NUL) begin
            mode = MODE_DONE;
        end else begin
            case (mode)
                MODE_DONE: begin
                    res = b;
                end
                MODE_PASS_THEN_NORMAL: begin
                    mode = MODE_NORMAL;
                end
                MODE_BLANK_THEN_BLOCK: begin
                    res  = CH_SPACE;
                    mode = MODE_BLOCK;
                end
                MODE_BLANK_THEN_NORM: begin
                    res  = CH_SPACE;
                    mode = MODE_NORMAL;
                end
                MODE_LINE: begin
                    if (b == CH_NL) mode = MODE_NORMAL;
                    else res = CH_SPACE;
                end
                MODE_BLOCK: begin
                    if (cmt_quote != CH_NUL && b == CH_BSLASH && nxt == cmt_quote) begin
                        res  = CH_SPACE;
                        mode = MODE_BLANK_THEN_BLOCK;
                    end else if (cmt_quote == CH_NUL && b == CH_STAR && nxt == CH_SLASH) begin
                        res  = CH_SPACE;
                        mode = MODE_BLANK_THEN_NORM;
                    end else begin
                        if (cmt_quote != CH_NUL) begin
                            if (b == cmt_quote) cmt_quote = CH_NUL;
                        end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                            cmt_quote = b;
                        end
                        if (b != CH_NL) res = CH_SPACE;
                    end
                end
                default: begin
                    mode = MODE_NORMAL;
                    if (str_quote != CH_NUL) begin
                        if (b == CH_BSLASH && nxt == str_quote) mode = MODE_PASS_THEN_NORMAL;
                        else if (b == str_quote) str_quote = CH_NUL;
                    end else if (b == comment_char && !last_was_bs) begin
                        res  = CH_SPACE;
                        mode = MODE_LINE;
                    end else if (b == CH_SLASH && nxt == CH_STAR) begin
                        res       = CH_SPACE;
                        cmt_quote = CH_NUL;
                        mode      = MODE_BLANK_THEN_BLOCK;
                    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                        str_quote = b;
                    end
                end
            endcase
        end
        last_was_bs = (res == CH_BSLASH);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            comment_char = LINE_CHAR_RESET;
            clear_scan();
            blanked_q.delete();
        end else begin
            if (i_cfg_we) comment_char = i_cfg_data;

            if (i_in_valid && i_in_ready) begin
                if (look_full) begin
                    want.out_byte = blank_byte(look_byte, i_in_item.in_byte);
                    want.out_last = 1'b0;
                    blanked_q.push_back(want);
                end
                if (i_in_item.in_last) begin
                    want.out_byte = blank_byte(i_in_item.in_byte, CH_NUL);
                    want.out_last = 1'b1;
                    blanked_q.push_back(want);
                    clear_scan();
                end else begin
                    look_byte = i_in_item.in_byte;
                    look_full = 1'b1;
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (blanked_q.size() == 0) begin
                    $error("unexpected output transaction: out_byte %h out_last %b",
                           i_out_item.out_byte, i_out_item.out_last);
                    fails++;
                end else begin
                    want = blanked_q.pop_front();
                    if (i_out_item.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h",
                               want.out_byte, i_out_item.out_byte);
                        fails++;
                    end
                    if (i_out_item.out_last !== want.out_last) begin
                        $error("out_last: expected %b, got %b",
                               want.out_last, i_out_item.out_last);
                        fails++;
                    end
                end
            end
        end
        o_outstanding <= blanked_q.size();
        o_fail_count  <= fails;
    end

endmodule

// ----- bench/tb_asm_comment_blanker.sv -----
// Testbench top for asm_comment_blanker: clock, reset, source text stimulus and verdict.
module tb_asm_comment_blanker
    import acb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Run-away guard, far above the slowest legal run (~700 items).
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Settle time after the last expected byte.
    localparam int SETTLE_CYCLES = 4;
    // Minimum items sent per comment-char setting (whole texts, so it may run over).
    localparam int CHUNK_ITEMS = 67;

    // Comment chars used, three per idling phase: '#' and ';', extremes, newline, the
    // slash pair marker, quote, backslash, and finally back to the reset value.
    localparam logic [7:0] LINE_CHARS [0:8] = '{
        8'h23, CH_NUL, CH_NL, 8'hFF, CH_SLASH, CH_DQUOTE, CH_BSLASH, 8'h3B, LINE_CHAR_RESET
    };
    // Idling per phase, in percent: sender gaps and receiver stalls.
    localparam int GAP_PCT   [0:2] = '{33, 74, 0};
    localparam int STALL_PCT [0:2] = '{74, 33, 0};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = '0;

    int fail_count;
    int outstanding;

    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          bytes_fed      = 0;
    int unsigned cycle_count    = 0;
    logic [7:0]  line_char      = LINE_CHAR_RESET;  // current setting, steers text generation
    logic [7:0]  text_bytes[$];                      // source text being built

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    asm_comment_blanker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    acb_blank_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // Receiver: ready drops at random at the current stall rate, one decision per cycle.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly characters that steer the scanner, some plain letters and raw bytes.
    // A raw byte is occasionally NUL, which stops scanning for the rest of the text.
    function automatic logic [7:0] source_char();
        case ($urandom_range(0, 11))
            0:       return CH_SLASH;
            1:       return CH_STAR;
            2:       return CH_BSLASH;
            3:       return CH_DQUOTE;
            4:       return CH_SQUOTE;
            5:       return CH_NL;
            6:       return line_char;
            7:       return CH_SPACE;
            8:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    // Quoted string; may hold an escaped close quote or comment markers, and may stay open.
    function automatic void add_string();
        logic [7:0] q;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        text_bytes.push_back(q);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0: begin
                    text_bytes.push_back(CH_BSLASH);
                    text_bytes.push_back(q);
                end
                1: begin
                    text_bytes.push_back(CH_SLASH);
                    text_bytes.push_back(CH_STAR);
                end
                2: begin
                    text_bytes.push_back(CH_STAR);
                    text_bytes.push_back(CH_SLASH);
                end
                3:       text_bytes.push_back(line_char);
                default: text_bytes.push_back(source_char());
            endcase
        end
        if ($urandom_range(0, 5) != 0) text_bytes.push_back(q);
    endfunction

    // One source text: comments and strings, mostly well formed, with random content,
    // mixed with loose bytes. Texts are short so that many end-of-text flushes happen.
    function automatic void compose_source();
        text_bytes.delete();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4))
                        text_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                end
                3: begin
                    // line comment, sometimes running to the end of the text
                    text_bytes.push_back(line_char);
                    repeat ($urandom_range(0, 5)) text_bytes.push_back(source_char());
                    if ($urandom_range(0, 5) != 0) text_bytes.push_back(CH_NL);
                end
                4: begin
                    // block comment, possibly holding strings, possibly unterminated
                    text_bytes.push_back(CH_SLASH);
                    text_bytes.push_back(CH_STAR);
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 3) == 0) add_string();
                        else text_bytes.push_back(source_char());
                    end
                    if ($urandom_range(0, 5) != 0) begin
                        text_bytes.push_back(CH_STAR);
                        text_bytes.push_back(CH_SLASH);
                    end
                end
                5: add_string();
                6: begin
                    // escaped comment char
                    text_bytes.push_back(CH_BSLASH);
                    text_bytes.push_back(line_char);
                end
                7: text_bytes.push_back(8'($urandom_range(0, 255)));
                8: text_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_NL);
                default: text_bytes.push_back(source_char());
            endcase
        end
    endfunction

    // Offer one byte after a random gap; valid is raised once and held until the
    // transaction goes through.
    task automatic feed_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_byte: b, in_last: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_fed++;
    endtask

    // Send the built text, marking its final byte as last.
    task automatic feed_text();
        for (int k = 0; k < text_bytes.size(); k++)
            feed_byte(text_bytes[k], k == text_bytes.size() - 1);
    endtask

    // Drop valid, wait until the checker holds no expectation, then let the block settle.
    // The first edge lets the checker's count catch up with the last transaction.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only called with the block idle and no text open.
    task automatic set_comment_char(input logic [7:0] c);
        cfg_we    <= 1'b1;
        cfg_data  <= c;
        line_char  = c;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int chunk_start;

        // Synchronous reset, asserted from the start, then released once.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed texts, comment char still at its reset value ----
        // Single-byte text: no lookahead held, max byte value.
        text_bytes = '{8'hFF};
        feed_text();
        // Escaped comment char, then a real line comment ended by newline.
        text_bytes.delete();
        begin
            string s;
            s = "\\@@x\na";
            text_bytes.delete();
            for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
            feed_text();
            // String with escaped quote and inert markers; block comment with a quoted
            // close marker inside and a kept newline; closing pair ends the text.
            s = "\"\\\"/*\"/*'*/'\n*/";
            text_bytes.delete();
            for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
            feed_text();
        end
        // NUL inside an open block comment: it and the following byte pass unchanged.
        text_bytes = '{CH_SLASH, CH_STAR, CH_NUL, 8'h78};
        feed_text();

        // ---- Random texts: three idling phases, three comment chars each ----
        for (int p = 0; p < 3; p++) begin
            send_gap_pct   = GAP_PCT[p];
            recv_stall_pct = STALL_PCT[p];
            for (int c = 0; c < 3; c++) begin
                drain_results();
                set_comment_char(LINE_CHARS[p * 3 + c]);
                chunk_start = bytes_fed;
                while (bytes_fed - chunk_start < CHUNK_ITEMS) begin
                    compose_source();
                    feed_text();
                end
            end
        end

        // Everything sent: wait for the last results, then give the verdict.
        drain_results();
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/acb_pkg.sv
rtl/core/acb_judge.sv
rtl/core/acb_out_fifo.sv
rtl/core/asm_comment_blanker.sv
bench/acb_blank_checker.sv
bench/tb_asm_comment_blanker.sv
